// File: hw/rtl/prc_pkg.sv
// Types and constants shared by the page range coalescer.
package prc_pkg;

  localparam int unsigned AddrW = 48;
  localparam int unsigned EndW  = 49;
  localparam int unsigned ShiftW = 5;
  localparam logic [ShiftW-1:0] ShiftMin   = 5'd9;
  localparam logic [ShiftW-1:0] ShiftMax   = 5'd16;
  localparam logic [ShiftW-1:0] ShiftReset = 5'd12;

  typedef struct packed {
    logic [AddrW-1:0] page_addr;
    logic             last_in_batch;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0] range_start;
    logic [EndW-1:0]  range_end;
    logic             flush_tlb;
    logic             last_range;
    logic             overflowed;
  } rsp_t;

  // Batch hand-off from the front end to the back end.
  typedef struct packed {
    logic valid;
    logic ovf;
  } batch_t;

endpackage

// File: hw/rtl/prc_sort_chain.sv
// Front end: insertion sorting chain that loads one address per transaction.
module prc_sort_chain #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrBits = 48
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic [AddrBits-1:0]        addr_i,
  input  logic                       pop_i,
  input  logic                       clear_i,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [AddrBits-1:0]        head_o,
  output logic                       head_last_o
);
  logic [AddrBits-1:0] val_q [Depth];
  logic [AddrBits-1:0] val_d [Depth];
  logic [Depth-1:0]    occ_q, occ_d;
  logic [Depth-1:0]    gt;

  // Cell i holds the i-th smallest; a new value goes in before every larger one.
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      gt[i] = occ_q[i] && (val_q[i] > addr_i);
    end
  end

  always_comb begin
    val_d = val_q;
    occ_d = occ_q;
    if (clear_i) begin
      occ_d = '0;
    end else if (pop_i) begin
      for (int i = 0; i < Depth - 1; i++) begin
        val_d[i] = val_q[i+1];
      end
      occ_d = occ_q >> 1;
    end else if (load_i) begin
      // Larger cells shift up one; the first shifted or free cell takes the new value.
      if (gt[0] || !occ_q[0]) val_d[0] = addr_i;
      for (int i = 1; i < Depth; i++) begin
        if (gt[i] || (occ_q[i-1] && !occ_q[i])) begin
          val_d[i] = gt[i-1] ? val_q[i-1] : addr_i;
        end
      end
      occ_d = {occ_q[Depth-2:0], 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign full_o      = occ_q[Depth-1];
  assign empty_o     = !occ_q[0];
  assign head_o      = val_q[0];
  assign head_last_o = occ_q[0] && !occ_q[1];
endmodule

// File: hw/rtl/prc_merge.sv
// Back end: walks the sorted chain and emits one merged range per transaction.
module prc_merge #(
  parameter int unsigned AddrBits = 48
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  prc_pkg::batch_t           batch_i,
  input  logic [prc_pkg::ShiftW-1:0] shift_i,
  input  logic                      empty_i,
  input  logic [AddrBits-1:0]       head_i,
  input  logic                      head_last_i,
  output logic                      pop_o,
  output logic                      done_o,
  output logic                      rsp_valid_o,
  output prc_pkg::rsp_t             rsp_o
);
  logic                  run_q, run_d;
  logic                  have_q, have_d;
  logic [AddrBits-1:0]   start_q, start_d, cur_q, cur_d;
  logic [AddrBits:0]     psz;
  logic [AddrBits:0]     diff;
  logic                  adj;
  logic [prc_pkg::ShiftW-1:0] sh;
  prc_pkg::rsp_t         rsp_d;
  logic                  rv_d, rv_q;
  prc_pkg::rsp_t         rsp_q;
  logic [AddrBits:0]     endv;

  always_comb begin
    sh = shift_i;
    if (sh < prc_pkg::ShiftMin) sh = prc_pkg::ShiftMin;
    if (sh > prc_pkg::ShiftMax) sh = prc_pkg::ShiftMax;
    psz  = (AddrBits+1)'(1) << sh;
    diff = {1'b0, head_i} - {1'b0, cur_q};
    adj  = (head_i == cur_q) || (diff == psz);
    endv = {1'b0, cur_q} + psz;
  end

  always_comb begin
    run_d   = run_q;
    have_d  = have_q;
    start_d = start_q;
    cur_d   = cur_q;
    pop_o   = 1'b0;
    done_o  = 1'b0;
    rv_d    = 1'b0;
    rsp_d   = rsp_q;
    if (!run_q) begin
      if (batch_i.valid) run_d = 1'b1;
    end else if (!have_q) begin
      start_d = head_i;
      cur_d   = head_i;
      have_d  = 1'b1;
      pop_o   = 1'b1;
      if (head_last_i) begin
        have_d = 1'b1;
      end
    end else if (!empty_i && adj) begin
      cur_d = head_i;
      pop_o = 1'b1;
    end else begin
      rv_d  = 1'b1;
      rsp_d.range_start = prc_pkg::AddrW'(start_q);
      rsp_d.range_end   = prc_pkg::EndW'(endv);
      rsp_d.flush_tlb   = empty_i;
      rsp_d.last_range  = empty_i;
      rsp_d.overflowed  = batch_i.ovf;
      if (empty_i) begin
        run_d  = 1'b0;
        have_d = 1'b0;
        done_o = 1'b1;
      end else begin
        start_d = head_i;
        cur_d   = head_i;
        pop_o   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      have_q <= 1'b0;
      rv_q   <= 1'b0;
    end else begin
      run_q  <= run_d;
      have_q <= have_d;
      rv_q   <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    cur_q   <= cur_d;
    rsp_q   <= rsp_d;
  end

  assign rsp_valid_o = rv_q;
  assign rsp_o       = rsp_q;
endmodule

// File: hw/rtl/page_range_coalescer.sv
// Top level of the page range coalescer.
//
// Usage: drive req_i and raise start while busy is low; each such
// transaction carries one page address. The transaction with last_in_batch
// set closes the batch. Addresses load one per cycle into a sorting chain
// of BATCH_CAPACITY cells, each inserted in order, so the batch is already
// sorted when it closes. Addresses arriving with the chain full are dropped
// and all results of that batch flag overflowed.
// After the closing transaction busy rises while the merge unit walks
// the chain, one entry per cycle, and emits one merged range per result
// transaction on rsp_o with rsp_valid_o high for one cycle. The receiver
// cannot stall. busy stays high as the walk starts, pops every entry and closes
// the last range. Each range result appears the cycle after the pop that ends
// it; the final one shows in the first cycle with busy low. Loading is one
// address per cycle while idle. The user must write page_shift through
// cfg_we_i/cfg_wdata_i only while idle; the block does not enforce it. Reset
// empties the chain, clears overflow and sets page_shift to 12.
module page_range_coalescer #(
  parameter int unsigned BATCH_CAPACITY = 64,
  parameter int unsigned ADDR_BITS = 48
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  prc_pkg::req_t               req_i,
  input  logic                        cfg_we_i,
  input  logic [prc_pkg::ShiftW-1:0]  cfg_wdata_i,
  output logic                        rsp_valid_o,
  output prc_pkg::rsp_t               rsp_o
);
  logic [prc_pkg::ShiftW-1:0] shift_q;
  logic                       ovf_q, ovf_d;
  logic                       pend_q, pend_d;
  logic                       accept, full, empty, hlast, pop, done;
  logic [ADDR_BITS-1:0]       head;
  prc_pkg::batch_t            batch;
  logic                       ovf_now;

  assign accept  = start && !busy;
  assign busy    = pend_q;
  assign ovf_now = ovf_q || full;

  // Queue between the sides: the chain itself; pend marks a closed batch.
  always_comb begin
    ovf_d  = ovf_q;
    pend_d = pend_q;
    if (accept) begin
      ovf_d = ovf_now;
      if (req_i.last_in_batch) pend_d = 1'b1;
    end
    if (done) begin
      pend_d = 1'b0;
      ovf_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= prc_pkg::ShiftReset;
      ovf_q   <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      if (cfg_we_i) shift_q <= cfg_wdata_i;
      ovf_q  <= ovf_d;
      pend_q <= pend_d;
    end
  end

  assign batch.valid = pend_q;
  assign batch.ovf   = ovf_q;

  prc_sort_chain #(.Depth(BATCH_CAPACITY), .AddrBits(ADDR_BITS)) u_chain (
    .clk_i, .rst_ni,
    .load_i(accept && !full),
    .addr_i(req_i.page_addr[ADDR_BITS-1:0]),
    .pop_i(pop),
    .clear_i(1'b0),
    .full_o(full),
    .empty_o(empty),
    .head_o(head),
    .head_last_o(hlast)
  );

  prc_merge #(.AddrBits(ADDR_BITS)) u_merge (
    .clk_i, .rst_ni,
    .batch_i(batch),
    .shift_i(shift_q),
    .empty_i(empty),
    .head_i(head),
    .head_last_i(hlast),
    .pop_o(pop),
    .done_o(done),
    .rsp_valid_o,
    .rsp_o
  );
endmodule

// File: hw/rtl/prc_checker.sv
// Port-level checker for the page range coalescer, bound to the top level.
module prc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          rsp_valid_o,
  input prc_pkg::rsp_t rsp_o
);
  a_flush_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.flush_tlb == rsp_o.last_range)) else $error("flush");
  a_valid_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> busy || $past(busy)) else $error("stray result");
  a_end_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> ({1'b0, rsp_o.range_start} < rsp_o.range_end)) else $error("range");
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.last_range) |-> !busy) else $error("busy stuck");
endmodule

bind page_range_coalescer prc_checker u_prc_checker (.*);

// File: dv/page_range_coalescer_tb.sv
// Testbench for the page range coalescer: directed and random batches against a local predictor.
`timescale 1ns / 1ps

module page_range_coalescer_tb;

  localparam int unsigned Capacity = 64;
  localparam int unsigned CycleLimit = 400000;
  // Extra wait after the block goes idle, sized from the batch capacity.
  localparam int unsigned DrainCycles = 2 * Capacity + 16;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  prc_pkg::req_t              req_i;
  logic                       cfg_we_i;
  logic [prc_pkg::ShiftW-1:0] cfg_wdata_i;
  logic                       rsp_valid_o;
  prc_pkg::rsp_t              rsp_o;

  page_range_coalescer #(
    .BATCH_CAPACITY(Capacity),
    .ADDR_BITS(prc_pkg::AddrW)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .req_i(req_i),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o(rsp_o)
  );

  // Predictor state: a mirror of the batch store, count, drop flag and page_shift.
  logic [prc_pkg::AddrW-1:0]  page_store [Capacity];
  int unsigned                page_count;
  logic                       batch_dropped;
  logic [prc_pkg::ShiftW-1:0] shift_mirror;
  prc_pkg::rsp_t              expected_ranges [$];

  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned burst_left;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Global watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Page size from page_shift, clamped to the legal 9..16 window.
  function automatic logic [prc_pkg::EndW-1:0] page_bytes(logic [prc_pkg::ShiftW-1:0] sh);
    logic [prc_pkg::ShiftW-1:0] s;
    s = sh;
    if (s < prc_pkg::ShiftMin) s = prc_pkg::ShiftMin;
    if (s > prc_pkg::ShiftMax) s = prc_pkg::ShiftMax;
    return {{(prc_pkg::EndW-1){1'b0}}, 1'b1} << s;
  endfunction

  // k pages at the current page size, as an address offset.
  function automatic logic [prc_pkg::AddrW-1:0] page_off(int unsigned k);
    logic [prc_pkg::EndW-1:0] p;
    p = page_bytes(shift_mirror);
    return prc_pkg::AddrW'(p * prc_pkg::EndW'(k));
  endfunction

  // Push one predicted range transaction.
  task automatic push_range(logic [prc_pkg::AddrW-1:0] lo, logic [prc_pkg::AddrW-1:0] hi,
                            logic fin);
    prc_pkg::rsp_t r;
    r.range_start = lo;
    r.range_end   = {1'b0, hi} + page_bytes(shift_mirror);
    r.flush_tlb   = fin;
    r.last_range  = fin;
    r.overflowed  = batch_dropped;
    expected_ranges.push_back(r);
  endtask

  // Apply one accepted transaction to the predictor.
  task automatic predict_page(logic [prc_pkg::AddrW-1:0] addr, logic last);
    logic [prc_pkg::AddrW-1:0] v;
    logic [prc_pkg::AddrW-1:0] lo;
    logic [prc_pkg::EndW-1:0]  psz;
    int j;
    if (page_count < Capacity) begin
      page_store[page_count] = addr;
      page_count++;
    end else begin
      batch_dropped = 1'b1;
    end
    if (!last) return;
    // Insertion sort, ascending.
    for (int i = 1; i < page_count; i++) begin
      v = page_store[i];
      j = i;
      while (j > 0 && page_store[j-1] > v) begin
        page_store[j] = page_store[j-1];
        j--;
      end
      page_store[j] = v;
    end
    psz = page_bytes(shift_mirror);
    lo = page_store[0];
    for (int i = 0; i + 1 < page_count; i++) begin
      // Equal or exactly one page apart merges; anything else closes the range.
      if (page_store[i+1] != page_store[i] &&
          ({1'b0, page_store[i+1]} - {1'b0, page_store[i]}) != psz) begin
        push_range(lo, page_store[i], 1'b0);
        lo = page_store[i+1];
      end
    end
    push_range(lo, page_store[page_count-1], 1'b1);
    page_count = 0;
    batch_dropped = 1'b0;
  endtask

  // Result checker: valid is a one-cycle strobe, sampled mid-cycle.
  always @(negedge clk_i) begin
    prc_pkg::rsp_t want;
    if (rst_ni && rsp_valid_o) begin
      if (expected_ranges.size() == 0) begin
        $error("unexpected range transaction start=%h end=%h",
               rsp_o.range_start, rsp_o.range_end);
        fail_count++;
      end else begin
        want = expected_ranges.pop_front();
        if (rsp_o.range_start !== want.range_start) begin
          $error("range_start exp %h got %h", want.range_start, rsp_o.range_start);
          fail_count++;
        end
        if (rsp_o.range_end !== want.range_end) begin
          $error("range_end exp %h got %h", want.range_end, rsp_o.range_end);
          fail_count++;
        end
        if (rsp_o.flush_tlb !== want.flush_tlb) begin
          $error("flush_tlb exp %b got %b", want.flush_tlb, rsp_o.flush_tlb);
          fail_count++;
        end
        if (rsp_o.last_range !== want.last_range) begin
          $error("last_range exp %b got %b", want.last_range, rsp_o.last_range);
          fail_count++;
        end
        if (rsp_o.overflowed !== want.overflowed) begin
          $error("overflowed exp %b got %b", want.overflowed, rsp_o.overflowed);
          fail_count++;
        end
      end
    end
  end

  // Send one page transaction. Called right after a rising edge; start is
  // left high so back-to-back sends never lower and raise it in one step.
  task automatic send_page(logic [prc_pkg::AddrW-1:0] addr, logic last);
    start <= 1'b1;
    req_i <= '{page_addr: addr, last_in_batch: last};
    forever begin
      @(negedge clk_i);
      if (!busy) break;
    end
    @(posedge clk_i);
    predict_page(addr, last);
  endtask

  task automatic idle_cycles(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Bursty sender: random burst lengths, random gaps between them.
  task automatic send_paced(logic [prc_pkg::AddrW-1:0] addr, logic last);
    send_page(addr, last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
    end else begin
      burst_left--;
    end
  endtask

  // Wait until all ranges are in and the block is idle, plus drain margin.
  task automatic wait_drained();
    idle_cycles(1);
    while (expected_ranges.size() != 0) @(posedge clk_i);
    forever begin
      @(negedge clk_i);
      if (!busy) break;
    end
    @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_shift(logic [prc_pkg::ShiftW-1:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    shift_mirror = v;
  endtask

  function automatic logic [prc_pkg::AddrW-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[prc_pkg::AddrW-1:0];
  endfunction

  // Directed: field extremes, duplicates, adjacency, near misses.
  task automatic test_directed();
    send_page('0, 1'b1);                       // single entry at zero
    send_page('1, 1'b1);                       // top address, end spills into bit 48
    send_page(48'h1000, 1'b0);                 // duplicates collapse
    send_page(48'h1000, 1'b0);
    send_page(48'h1000, 1'b1);
    send_page(48'h5000, 1'b0);                 // out of order, adjacent chain
    send_page(48'h3000, 1'b0);
    send_page(48'h4000, 1'b0);
    send_page(48'h9000, 1'b1);                 // separate range
    send_page(48'h2000, 1'b0);                 // one byte past a page: no merge
    send_page(48'h3001, 1'b0);
    send_page(48'h2003, 1'b0);                 // unaligned neighbors
    send_page(48'h3003, 1'b1);
    send_page('1, 1'b0);                       // wraps nowhere: top and zero stay apart
    send_page(48'hFFFF_FFFF_F000, 1'b0);
    send_page('0, 1'b1);
    send_page(48'hAAAA_AAAA_A000, 1'b0);
    send_page(48'h5555_5555_5000, 1'b1);
    idle_cycles(1);
  endtask

  // Store full: extra addresses dropped, the closing one too.
  task automatic test_overflow();
    logic [prc_pkg::AddrW-1:0] base;
    base = rand_addr();
    for (int i = 0; i < Capacity + 3; i++)
      send_page(base + page_off(i), i == Capacity + 2);
    wait_drained();
    // Exactly full, no drop.
    for (int i = 0; i < Capacity; i++) send_paced(rand_addr(), i == Capacity - 1);
    wait_drained();
    // Next batch after overflow must start clean.
    send_page(48'h7000, 1'b1);
    idle_cycles(1);
  endtask

  // Page shift settings, clamped extremes included.
  task automatic test_shift_settings();
    logic [prc_pkg::ShiftW-1:0] shifts [7] = '{5'd0, 5'd8, 5'd9, 5'd16, 5'd17, 5'd31, 5'd13};
    logic [prc_pkg::AddrW-1:0] base;
    foreach (shifts[k]) begin
      write_shift(shifts[k]);
      base = rand_addr();
      send_page(base, 1'b0);
      send_page(base + page_off(1), 1'b0);
      send_page(base + prc_pkg::AddrW'(page_bytes(shift_mirror) >> 1), 1'b0);
      send_page(base + page_off(2), 1'b1);
      idle_cycles(1);
    end
  endtask

  // Random batches: mostly structured runs, some pure noise, few full-size.
  task automatic test_random(int unsigned items);
    int unsigned sent;
    int unsigned n;
    bit paused;
    logic [prc_pkg::AddrW-1:0] base;
    logic [prc_pkg::AddrW-1:0] a;
    sent = 0;
    paused = 1'b0;
    while (sent < items) begin
      if (!paused && sent > items / 2) begin
        // Hold off once until every range is back.
        wait_drained();
        write_shift(prc_pkg::ShiftW'($urandom_range(9, 16)));
        paused = 1'b1;
      end
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, Capacity + 4)
                                         : $urandom_range(1, 8);
      base = rand_addr() & ~48'hFFFF;
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 5))
          0: a = rand_addr();
          1: a = base;
          2: a = base + page_off($urandom_range(0, 2)) + 48'd1;
          default: a = base + page_off($urandom_range(0, 10));
        endcase
        send_paced(a, i == n - 1);
      end
      sent += n;
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    fail_count   = 0;
    cycle_count  = 0;
    burst_left   = 0;
    page_count   = 0;
    batch_dropped = 1'b0;
    shift_mirror = prc_pkg::ShiftReset;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_overflow();
    test_shift_settings();
    write_shift(prc_pkg::ShiftReset);
    test_random(110);

    wait_drained();
    if (fail_count == 0 && expected_ranges.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/prc_pkg.sv
hw/rtl/prc_sort_chain.sv
hw/rtl/prc_merge.sv
hw/rtl/page_range_coalescer.sv
hw/rtl/prc_checker.sv
dv/page_range_coalescer_tb.sv
